// ===== rtl/clns_pkg.sv =====
// Shared constants, request codes and controller/datapath types for the LCD nibble sequencer.
`timescale 1ns / 1ps

package clns_pkg;

	// Display geometry.
	localparam int LINE_CHARS = 20;
	localparam int MAX_COLUMN = 40;

	// Port and field widths.
	localparam int CMD_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int COL_W    = 6;
	localparam int NUM_W    = 16;
	localparam int NIB_W    = 4;
	localparam int IN_DW    = 32;
	localparam int OUT_DW   = 8;

	// Decimal conversion: five BCD digits cover a 16-bit value.
	localparam int DIGITS   = 5;
	localparam int BCD_W    = DIGITS * NIB_W;
	localparam int ITER_W   = $clog2(NUM_W);
	localparam int DCNT_W   = $clog2(DIGITS + 1);

	// Nibble counts per request.
	localparam int INIT_NIBS  = 14;
	localparam int BYTE_NIBS  = 2;
	localparam int CLEAR_NIBS = 4 + 2 * LINE_CHARS;
	localparam int MAX_NIBS   = (CLEAR_NIBS > INIT_NIBS) ? CLEAR_NIBS : INIT_NIBS;
	localparam int CNT_W      = $clog2(MAX_NIBS);

	localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
	localparam logic [NIB_W-1:0]  ASCII_HI   = 4'h3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT    = 3'd0,
		CMD_COMMAND = 3'd1,
		CMD_DATA    = 3'd2,
		CMD_GOTO    = 3'd3,
		CMD_CLEAR   = 3'd4,
		CMD_DECIMAL = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_STRIP,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic conv;
		logic strip;
		logic emit;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_empty;
		logic in_decimal;
		logic conv_last;
		logic strip_done;
		logic out_free;
		logic emit_last;
	} stat_t;

endpackage

// ===== rtl/clns_ctrl.sv =====
// Controller state machine for the LCD nibble sequencer.
`timescale 1ns / 1ps

module clns_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  clns_pkg::stat_t stat,
	output clns_pkg::ctl_t  ctl
);
	import clns_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (stat.in_empty) begin
						state_d = ST_IDLE;
					end else if (stat.in_decimal) begin
						state_d = ST_CONV;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_CONV: begin
				if (stat.conv_last) begin
					state_d = ST_STRIP;
				end
			end
			ST_STRIP: begin
				if (stat.strip_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free && stat.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		ctl       = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ctl.load = s_tvalid;
			end
			ST_CONV: begin
				ctl.conv = 1'b1;
			end
			ST_STRIP: begin
				ctl.strip = 1'b1;
			end
			ST_EMIT: begin
				ctl.emit = stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/clns_dp.sv =====
// Datapath for the LCD nibble sequencer: request registers, BCD converter and output register.
`timescale 1ns / 1ps

module clns_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [clns_pkg::CMD_W-1:0]    s_tuser,
	input  logic [clns_pkg::IN_DW-1:0]    s_tdata,
	input  clns_pkg::ctl_t                ctl,
	output clns_pkg::stat_t               stat,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [clns_pkg::OUT_DW-1:0]   m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);
	import clns_pkg::*;

	// Power-up nibbles for 4-bit mode followed by the init command bytes.
	localparam logic [NIB_W-1:0] INIT_NIB [16] = '{
		4'h3, 4'h3, 4'h3, 4'h2,
		4'h2, 4'h8, 4'h1, 4'h0, 4'h0, 4'h6, 4'h0, 4'hC, 4'h0, 4'h1,
		4'h0, 4'h0
	};

	cmd_t               in_cmd;
	logic [BYTE_W-1:0]  in_byte;
	logic [COL_W-1:0]   in_col;
	logic               in_row;
	logic [NUM_W-1:0]   in_num;
	logic [CNT_W-1:0]   in_total;
	logic               in_empty;

	cmd_t               cmd_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [NUM_W-1:0]   bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   bcd_adj;
	logic [ITER_W-1:0]  iter_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   total_q;
	logic [CNT_W-1:0]   total_w;
	logic               lead_zero;

	logic               out_valid_q;
	logic [NIB_W-1:0]   out_nib_q;
	logic               out_rs_q;
	logic               out_last_q;

	logic [BYTE_W-1:0]  sel_byte;
	logic [NIB_W-1:0]   nib_d;
	logic               rs_d;

	assign in_cmd  = cmd_t'(s_tuser);
	assign in_byte = s_tdata[7:0];
	assign in_col  = s_tdata[13:8];
	assign in_row  = s_tdata[14];
	assign in_num  = s_tdata[30:15];

	always_comb begin
		in_total = '0;
		in_empty = 1'b0;
		case (in_cmd)
			CMD_INIT: begin
				in_total = CNT_W'(INIT_NIBS);
			end
			CMD_COMMAND, CMD_DATA: begin
				in_total = CNT_W'(BYTE_NIBS);
			end
			CMD_GOTO: begin
				in_total = CNT_W'(BYTE_NIBS);
				in_empty = ({1'b0, in_col} >= (COL_W + 1)'(MAX_COLUMN));
			end
			CMD_CLEAR: begin
				in_total = CNT_W'(CLEAR_NIBS);
			end
			CMD_DECIMAL: begin
				in_total = '0;
			end
			default: begin
				in_empty = 1'b1;
			end
		endcase
	end

	// Add-3 correction on every BCD digit of five or more before each shift.
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*NIB_W +: NIB_W] >= 4'd5) begin
				bcd_adj[i*NIB_W +: NIB_W] = bcd_q[i*NIB_W +: NIB_W] + 4'd3;
			end else begin
				bcd_adj[i*NIB_W +: NIB_W] = bcd_q[i*NIB_W +: NIB_W];
			end
		end
	end

	assign lead_zero = (bcd_q[BCD_W-1 -: NIB_W] == '0) && (dcnt_q > DCNT_W'(1));
	assign total_w   = (cmd_q == CMD_DECIMAL) ? CNT_W'({dcnt_q, 1'b0}) : total_q;

	assign stat.in_empty   = in_empty;
	assign stat.in_decimal = (in_cmd == CMD_DECIMAL);
	assign stat.conv_last  = (iter_q == '1);
	assign stat.strip_done = !lead_zero;
	assign stat.out_free   = !out_valid_q || m_tready;
	assign stat.emit_last  = (n_q == total_w - CNT_W'(1));

	// Nibble for the current position of the run.
	always_comb begin
		sel_byte = byte_q;
		nib_d    = '0;
		rs_d     = 1'b0;
		case (cmd_q)
			CMD_INIT: begin
				nib_d = INIT_NIB[n_q[3:0]];
			end
			CMD_COMMAND, CMD_GOTO: begin
				nib_d = n_q[0] ? sel_byte[3:0] : sel_byte[7:4];
			end
			CMD_DATA: begin
				nib_d = n_q[0] ? sel_byte[3:0] : sel_byte[7:4];
				rs_d  = 1'b1;
			end
			CMD_CLEAR: begin
				if (n_q >= CNT_W'(2) && n_q < CNT_W'(CLEAR_NIBS - 2)) begin
					sel_byte = SPACE_CHAR;
					rs_d     = 1'b1;
				end
				nib_d = n_q[0] ? sel_byte[3:0] : sel_byte[7:4];
			end
			CMD_DECIMAL: begin
				nib_d = n_q[0] ? bcd_q[BCD_W-1 -: NIB_W] : ASCII_HI;
				rs_d  = 1'b1;
			end
			default: begin
				nib_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= in_cmd;
			byte_q  <= (in_cmd == CMD_GOTO) ? {1'b1, in_row, in_col} : in_byte;
			bin_q   <= in_num;
			bcd_q   <= '0;
			iter_q  <= '0;
			dcnt_q  <= DCNT_W'(DIGITS);
			n_q     <= '0;
			total_q <= in_total;
		end else if (ctl.conv) begin
			{bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
			iter_q         <= iter_q + ITER_W'(1);
		end else if (ctl.strip) begin
			if (lead_zero) begin
				bcd_q  <= {bcd_q[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
		end else if (ctl.emit) begin
			n_q <= n_q + CNT_W'(1);
			if (cmd_q == CMD_DECIMAL && n_q[0]) begin
				bcd_q <= {bcd_q[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_nib_q  <= nib_d;
			out_rs_q   <= rs_d;
			out_last_q <= stat.emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DW'(out_nib_q);
	assign m_tuser  = out_rs_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/char_lcd_nibble_sequencer_top.sv =====
// Top level of the character LCD 4-bit nibble sequencer.
`timescale 1ns / 1ps

// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+--------------------------------------------------
// request   | in  | s_tvalid/s_tready  | s_tuser = cmd; s_tdata = byte_value, col, row, number
// nibble    | out | m_tvalid/m_tready  | m_tdata = nibble; m_tuser = reg_select; m_tlast = last
//
// A request is taken, then its run of N nibbles (init 14, byte requests 2, clear line
// 44) leaves at one nibble per cycle while the output is not stalled. Write decimal
// first runs the shift-and-add-3 BCD converter and drops leading zeros, then emits 2
// to 10 nibbles. A goto beyond the last column or an unused code is taken and emits
// nothing.
// Reset (arst_n low) empties the output register and returns the controller to idle.
// A stalled output holds its nibble; the next request is taken while the last nibble
// of the previous run still waits in the output register.

module char_lcd_nibble_sequencer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [clns_pkg::CMD_W-1:0]  s_tuser,  // cmd[2:0]
	input  logic [clns_pkg::IN_DW-1:0]  s_tdata,  // byte_value[7:0], col[13:8], row[14],
	                                              // number[30:15], zero[31]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [clns_pkg::OUT_DW-1:0] m_tdata,  // nibble[3:0], zero[7:4]
	output logic                        m_tuser,  // reg_select[0]
	output logic                        m_tlast
);
	import clns_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	// The controller sequences load, conversion, zero stripping and emission.
	clns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// The datapath holds the request, the BCD digits, the nibble counter and the output item.
	clns_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.ctl      (ctl),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/clns_chk.sv =====
// Port-level checker for the LCD nibble sequencer, bound to the top level.
`timescale 1ns / 1ps

module clns_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [clns_pkg::OUT_DW-1:0] m_tdata,
	input logic                        m_tuser,
	input logic                        m_tlast
);
	import clns_pkg::*;

	// A stalled output item keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output item changed while stalled");

	// Only the low nibble of the output data is ever used.
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DW-1:NIB_W] == '0)
		else $error("output padding bits not zero");

	// No new request is taken while a run is still in progress.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("request accepted in the middle of a nibble run");

endmodule

bind char_lcd_nibble_sequencer_top clns_chk u_clns_chk (.*);

// ===== test/char_lcd_nibble_sequencer_top_tb.sv =====
// Self-checking testbench for the character LCD 4-bit nibble sequencer top level.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_top_tb;
	import clns_pkg::*;

	// Run shape. The random part stops after this many requests that the block acts on;
	// the unused codes come on top.
	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_ITEMS   = 415;
	localparam int HOLD_AT        = 220;
	localparam int QUIET_FROM     = 100;
	localparam int QUIET_TO       = 170;
	localparam int DRAIN_CYCLES   = 64;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DIRECTED_ROWS  = 23;

	// Request codes the block must ignore.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	// HD44780 4-bit power-up sequence and command bits.
	localparam logic [NIB_W-1:0]  WAKE_NIB      = 4'h3;
	localparam logic [NIB_W-1:0]  FOUR_BIT_NIB  = 4'h2;
	localparam logic [BYTE_W-1:0] FUNCTION_SET  = 8'h28;
	localparam logic [BYTE_W-1:0] CURSOR_SHIFT  = 8'h10;
	localparam logic [BYTE_W-1:0] ENTRY_MODE    = 8'h06;
	localparam logic [BYTE_W-1:0] DISPLAY_ON    = 8'h0C;
	localparam logic [BYTE_W-1:0] CLEAR_DISPLAY = 8'h01;
	localparam logic [BYTE_W-1:0] DDRAM_SET     = 8'h80;
	localparam logic [BYTE_W-1:0] ROW1_OFFSET   = 8'h40;
	localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'd48;

	localparam logic RS_COMMAND = 1'b0;
	localparam logic RS_DATA    = 1'b1;

	// One nibble as it should leave the block.
	typedef struct packed {
		logic [NIB_W-1:0] nib;
		logic             rs;
		logic             last;
	} lcd_nibble_t;

	// One row of the directed table. Rows with typed set carry their expected run inline,
	// first nibble in the top bits of typed_nibs, all with the same register select.
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] byte_value;
		logic [COL_W-1:0]  col;
		logic              row;
		logic [NUM_W-1:0]  number;
		logic              typed;
		logic [3:0]        typed_len;
		logic              typed_rs;
		logic [39:0]       typed_nibs;
	} lcd_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [CMD_W-1:0]    s_tuser  = '0;
	logic [IN_DW-1:0]    s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_DW-1:0]   m_tdata;
	logic                m_tuser;
	logic                m_tlast;

	// Nibbles predicted for accepted requests, oldest first.
	lcd_nibble_t expected_nibbles[$];

	// Scratch run built by the predictor before it goes into the store.
	logic [NIB_W-1:0] run_nib [0:MAX_NIBS-1];
	logic             run_rs  [0:MAX_NIBS-1];
	int               run_len = 0;

	lcd_row_t directed_rows [0:DIRECTED_ROWS-1];

	int mismatch_count = 0;
	int stuck_cycles   = 0;
	int ready_hold     = 0;
	bit no_gaps        = 1'b0;

	char_lcd_nibble_sequencer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Gap lengths for both sides: mostly none, often short, now and then a long one.
	// During the quiet stretch neither side idles at all.
	function automatic int pick_gap();
		int roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 96)
			return $urandom_range(1, 3);
		return $urandom_range(12, 50);
	endfunction

	function automatic void add_nibble(input logic [NIB_W-1:0] nib, input logic rs);
		run_nib[run_len] = nib;
		run_rs[run_len]  = rs;
		run_len++;
	endfunction

	// A byte always goes out high nibble first.
	function automatic void add_byte(input logic [BYTE_W-1:0] b, input logic rs);
		add_nibble(b[7:4], rs);
		add_nibble(b[3:0], rs);
	endfunction

	// Moves the scratch run into the store and flags its final nibble.
	function automatic void commit_run();
		lcd_nibble_t item;
		for (int k = 0; k < run_len; k++) begin
			item.nib  = run_nib[k];
			item.rs   = run_rs[k];
			item.last = (k == run_len - 1);
			expected_nibbles.push_back(item);
		end
		run_len = 0;
	endfunction

	// Works out the nibble run that one request produces and queues it.
	function automatic void expand_request(input logic [CMD_W-1:0] cmd,
			input logic [BYTE_W-1:0] byte_value, input logic [COL_W-1:0] col,
			input logic row, input logic [NUM_W-1:0] number);
		logic [NIB_W-1:0]  digits [0:DIGITS-1];
		logic [NUM_W-1:0]  rest;
		logic [BYTE_W-1:0] addr;
		int                ndig;
		case (cmd)
		CMD_INIT: begin
			add_nibble(WAKE_NIB, RS_COMMAND);
			add_nibble(WAKE_NIB, RS_COMMAND);
			add_nibble(WAKE_NIB, RS_COMMAND);
			add_nibble(FOUR_BIT_NIB, RS_COMMAND);
			add_byte(FUNCTION_SET, RS_COMMAND);
			add_byte(CURSOR_SHIFT, RS_COMMAND);
			add_byte(ENTRY_MODE, RS_COMMAND);
			add_byte(DISPLAY_ON, RS_COMMAND);
			add_byte(CLEAR_DISPLAY, RS_COMMAND);
		end
		CMD_COMMAND: begin
			add_byte(byte_value, RS_COMMAND);
		end
		CMD_DATA: begin
			add_byte(byte_value, RS_DATA);
		end
		CMD_GOTO: begin
			// Columns past the end of the line produce nothing at all.
			if (col < MAX_COLUMN) begin
				addr = DDRAM_SET | {2'b00, col};
				if (row)
					addr = addr | ROW1_OFFSET;
				add_byte(addr, RS_COMMAND);
			end
		end
		CMD_CLEAR: begin
			add_byte(byte_value, RS_COMMAND);
			for (int k = 0; k < LINE_CHARS; k++)
				add_byte(SPACE_CHAR, RS_DATA);
			add_byte(byte_value, RS_COMMAND);
		end
		CMD_DECIMAL: begin
			// Digits are collected least significant first; zero still gives one digit.
			rest = number;
			ndig = 0;
			do begin
				digits[ndig] = NIB_W'(rest % 10);
				rest = NUM_W'(rest / 10);
				ndig++;
			end while (rest != 0);
			for (int k = ndig - 1; k >= 0; k--)
				add_byte(ASCII_ZERO + digits[k], RS_DATA);
		end
		default: begin
		end
		endcase
		commit_run();
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	// Presents one request and holds it until the block takes it. On return the clock
	// edge that accepted the item has just passed, and tvalid is still high.
	task automatic send_request(input logic [CMD_W-1:0] cmd,
			input logic [BYTE_W-1:0] byte_value, input logic [COL_W-1:0] col,
			input logic row, input logic [NUM_W-1:0] number);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, number, row, col, byte_value};
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
	endtask

	// Drops tvalid only when a gap is actually taken, so back-to-back items keep it high.
	task automatic pause_sender();
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Receiver back-pressure: after each stall tready is raised again before another stall begins.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			m_tready <= 1'b0;
			ready_hold--;
		end else begin
			m_tready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	// Every accepted nibble is compared with the oldest prediction.
	always @(posedge clk) begin : check_nibbles
		lcd_nibble_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (expected_nibbles.size() == 0) begin
				report_mismatch($sformatf("unexpected nibble %h rs %b last %b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = expected_nibbles.pop_front();
				if (m_tdata !== {{(OUT_DW - NIB_W){1'b0}}, want.nib})
					report_mismatch($sformatf("nibble %h, expected %h", m_tdata, want.nib));
				if (m_tuser !== want.rs)
					report_mismatch($sformatf("reg_select %b, expected %b", m_tuser, want.rs));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
			end
		end
	end

	// Ends a hung run: too many cycles in a row with no item moving on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		lcd_row_t         cur;
		logic [CMD_W-1:0]  r_cmd;
		logic [BYTE_W-1:0] r_byte;
		logic [COL_W-1:0]  r_col;
		logic              r_row;
		logic [NUM_W-1:0]  r_num;
		int                roll;
		int                counted;
		bit                held_once;

		// Directed table: extremes of each field, every request code, the goto column
		// limit on both rows, zero and the largest value for the decimal writer, and the
		// unused codes with all other fields at ones.
		directed_rows[0]  = '{CMD_INIT,     8'h00, 6'd0,  1'b0, 16'd0,     1'b0, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[1]  = '{CMD_COMMAND,  8'h00, 6'd0,  1'b0, 16'd0,     1'b1, 4'd2,
			RS_COMMAND, 40'h00_00000000};
		directed_rows[2]  = '{CMD_COMMAND,  8'hFF, 6'd63, 1'b1, 16'hFFFF,  1'b1, 4'd2,
			RS_COMMAND, 40'hFF_00000000};
		directed_rows[3]  = '{CMD_DATA,     8'h00, 6'd63, 1'b1, 16'hFFFF,  1'b1, 4'd2,
			RS_DATA,    40'h00_00000000};
		directed_rows[4]  = '{CMD_DATA,     8'hFF, 6'd0,  1'b0, 16'd0,     1'b1, 4'd2,
			RS_DATA,    40'hFF_00000000};
		directed_rows[5]  = '{CMD_DATA,     8'h5A, 6'd21, 1'b0, 16'h5555,  1'b0, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[6]  = '{CMD_COMMAND,  8'hA5, 6'd42, 1'b1, 16'hAAAA,  1'b0, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[7]  = '{CMD_GOTO,     8'hFF, 6'd0,  1'b0, 16'hFFFF,  1'b1, 4'd2,
			RS_COMMAND, 40'h80_00000000};
		directed_rows[8]  = '{CMD_GOTO,     8'h00, 6'd39, 1'b1, 16'd0,     1'b1, 4'd2,
			RS_COMMAND, 40'hE7_00000000};
		directed_rows[9]  = '{CMD_GOTO,     8'h00, 6'd40, 1'b0, 16'd0,     1'b1, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[10] = '{CMD_GOTO,     8'hFF, 6'd63, 1'b1, 16'hFFFF,  1'b1, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[11] = '{CMD_GOTO,     8'h3C, 6'd21, 1'b1, 16'h1234,  1'b0, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[12] = '{CMD_CLEAR,    8'h80, 6'd0,  1'b0, 16'd0,     1'b0, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[13] = '{CMD_CLEAR,    8'hC0, 6'd63, 1'b1, 16'hFFFF,  1'b0, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[14] = '{CMD_DECIMAL,  8'hFF, 6'd63, 1'b1, 16'd0,     1'b1, 4'd2,
			RS_DATA,    40'h30_00000000};
		directed_rows[15] = '{CMD_DECIMAL,  8'h00, 6'd0,  1'b0, 16'd65535, 1'b1, 4'd10,
			RS_DATA,    40'h36_35_35_33_35};
		directed_rows[16] = '{CMD_DECIMAL,  8'h00, 6'd0,  1'b0, 16'd9,     1'b0, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[17] = '{CMD_DECIMAL,  8'h00, 6'd0,  1'b0, 16'd10,    1'b0, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[18] = '{CMD_DECIMAL,  8'h00, 6'd0,  1'b0, 16'd10000, 1'b0, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[19] = '{CMD_DECIMAL,  8'h00, 6'd0,  1'b0, 16'd9999,  1'b0, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[20] = '{CMD_SPARE_LO, 8'hFF, 6'd63, 1'b1, 16'hFFFF,  1'b1, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[21] = '{CMD_SPARE_HI, 8'hFF, 6'd63, 1'b1, 16'hFFFF,  1'b1, 4'd0,
			RS_COMMAND, 40'h0};
		directed_rows[22] = '{CMD_INIT,     8'hFF, 6'd63, 1'b1, 16'hFFFF,  1'b0, 4'd0,
			RS_COMMAND, 40'h0};

		// Reset is held from time zero and released once, at a clock edge.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			cur = directed_rows[r];
			send_request(cur.cmd, cur.byte_value, cur.col, cur.row, cur.number);
			if (cur.typed) begin
				for (int k = 0; k < cur.typed_len; k++)
					add_nibble(cur.typed_nibs[39 - 4 * k -: 4], cur.typed_rs);
				commit_run();
			end else begin
				expand_request(cur.cmd, cur.byte_value, cur.col, cur.row, cur.number);
			end
			pause_sender();
		end

		// Random part. Short requests dominate; init and clear line are rarer since they are
		// long runs. Decimal values are spread over every digit count, and goto columns
		// cover the whole field so roughly a third fall past the line end.
		counted   = 0;
		held_once = 1'b0;
		while (counted < RANDOM_ITEMS) begin
			no_gaps = (counted >= QUIET_FROM) && (counted < QUIET_TO);
			r_byte  = BYTE_W'($urandom);
			r_col   = COL_W'($urandom);
			r_row   = 1'($urandom);
			r_num   = NUM_W'($urandom);
			roll    = $urandom_range(0, 99);
			if (roll < 4)
				r_cmd = CMD_INIT;
			else if (roll < 10)
				r_cmd = CMD_CLEAR;
			else if (roll < 28)
				r_cmd = CMD_COMMAND;
			else if (roll < 50)
				r_cmd = CMD_DATA;
			else if (roll < 70)
				r_cmd = CMD_GOTO;
			else if (roll < 95) begin
				r_cmd = CMD_DECIMAL;
				case ($urandom_range(0, 3))
				0: r_num = NUM_W'($urandom_range(0, 9));
				1: r_num = NUM_W'($urandom_range(10, 999));
				2: r_num = NUM_W'($urandom_range(10000, 65535));
				default: begin
				end
				endcase
			end else
				r_cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;

			send_request(r_cmd, r_byte, r_col, r_row, r_num);
			expand_request(r_cmd, r_byte, r_col, r_row, r_num);
			if (r_cmd != CMD_SPARE_LO && r_cmd != CMD_SPARE_HI)
				counted++;

			// Once, midway, the sender holds off until every predicted nibble has come out.
			if (!held_once && counted == HOLD_AT) begin
				held_once = 1'b1;
				s_tvalid <= 1'b0;
				while (expected_nibbles.size() != 0) @(posedge clk);
			end else begin
				pause_sender();
			end
		end
		no_gaps = 1'b0;

		// Drain: the watchdog bounds this wait if nibbles never arrive.
		s_tvalid <= 1'b0;
		while (expected_nibbles.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
